FILE: rtl/core/wheel_encoder_speed_position_macros.svh
// Assertion macros shared by the wheel encoder RTL.
`ifndef WHEEL_ENCODER_SPEED_POSITION_MACROS_SVH
`define WHEEL_ENCODER_SPEED_POSITION_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define WESP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wesp: implication check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define WESP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wesp: next-cycle check failed");

`endif

FILE: rtl/core/wesp_pkg.sv
// Types and constants shared by the wheel encoder speed and position block.
package wesp_pkg;

   localparam int IPR_WIDTH       = 16;
   localparam int STALL_WIDTH     = 20;
   localparam int SCALE_WIDTH     = 24;
   localparam int AVG_CNT_WIDTH   = 4;
   localparam int SUM_WIDTH       = 24;
   localparam int DIV_WIDTH       = 24;
   localparam int IMP_WIDTH       = 17;
   localparam int REV_WIDTH       = 32;
   localparam int DIR_WIDTH       = 2;
   localparam int SPEED_WIDTH     = 25;
   localparam int CMD_WIDTH       = 2;
   localparam int REQ_DATA_WIDTH  = 8;
   localparam int RSP_DATA_WIDTH  = 80;
   localparam int CSR_ADDR_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [IPR_WIDTH-1:0]     IPR_RESET     = 16'd500;
   localparam logic [STALL_WIDTH-1:0]   STALL_RESET   = 20'd100000;
   localparam logic [SCALE_WIDTH-1:0]   SCALE_RESET   = 24'd12000;
   localparam logic [AVG_CNT_WIDTH-1:0] AVG_CNT_RESET = 4'd5;

   localparam logic signed [DIR_WIDTH-1:0] DIR_REV  = 2'sb11;
   localparam logic signed [DIR_WIDTH-1:0] DIR_FWD  = 2'sb01;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_TICK  = 2'd0,
      CMD_EDGE  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_IMPULSES_PER_REV = 2'd0,
      REG_STALL_LIMIT      = 2'd1,
      REG_SPEED_SCALE      = 2'd2,
      REG_AVERAGE_COUNT    = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_RESULT = 2'd2
   } state_type;

   typedef struct packed {
      logic [IPR_WIDTH-1:0]     impulses_per_rev;
      logic [STALL_WIDTH-1:0]   stall_limit;
      logic [SCALE_WIDTH-1:0]   speed_scale;
      logic [AVG_CNT_WIDTH-1:0] average_count;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_busy;
      logic div_done;
   } dp_status_type;

endpackage

FILE: rtl/core/wesp_csr.sv
// Configuration register file behind the APB-style port.
module wesp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wesp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [wesp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [wesp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output wesp_pkg::cfg_type                   cfg
);
   import wesp_pkg::*;

   logic [IPR_WIDTH-1:0]     ipr_ff,   ipr_in;
   logic [STALL_WIDTH-1:0]   stall_ff, stall_in;
   logic [SCALE_WIDTH-1:0]   scale_ff, scale_in;
   logic [AVG_CNT_WIDTH-1:0] avg_ff,   avg_in;
   logic                     wr_en;
   csr_reg_type              reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_reg_type'(csr_paddr[3:2]);

   always_comb begin
      ipr_in   = ipr_ff;
      stall_in = stall_ff;
      scale_in = scale_ff;
      avg_in   = avg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_IMPULSES_PER_REV: ipr_in   = csr_pwdata[IPR_WIDTH-1:0];
            REG_STALL_LIMIT:      stall_in = csr_pwdata[STALL_WIDTH-1:0];
            REG_SPEED_SCALE:      scale_in = csr_pwdata[SCALE_WIDTH-1:0];
            REG_AVERAGE_COUNT:    avg_in   = csr_pwdata[AVG_CNT_WIDTH-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_IMPULSES_PER_REV: csr_prdata = CSR_DATA_WIDTH'(ipr_ff);
         REG_STALL_LIMIT:      csr_prdata = CSR_DATA_WIDTH'(stall_ff);
         REG_SPEED_SCALE:      csr_prdata = CSR_DATA_WIDTH'(scale_ff);
         REG_AVERAGE_COUNT:    csr_prdata = CSR_DATA_WIDTH'(avg_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ipr_ff   <= IPR_RESET;
         stall_ff <= STALL_RESET;
         scale_ff <= SCALE_RESET;
         avg_ff   <= AVG_CNT_RESET;
      end else begin
         ipr_ff   <= ipr_in;
         stall_ff <= stall_in;
         scale_ff <= scale_in;
         avg_ff   <= avg_in;
      end
   end

   assign cfg.impulses_per_rev = ipr_ff;
   assign cfg.stall_limit      = stall_ff;
   assign cfg.speed_scale      = scale_ff;
   assign cfg.average_count    = avg_ff;

endmodule

FILE: rtl/core/wesp_div.sv
// Serial restoring divider, one quotient bit per cycle.
`include "wheel_encoder_speed_position_macros.svh"
module wesp_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [wesp_pkg::DIV_WIDTH-1:0] dividend,
   input  logic [wesp_pkg::DIV_WIDTH-1:0] divisor,
   output logic                           busy,
   output logic                           done,
   output logic [wesp_pkg::DIV_WIDTH-1:0] quotient
);
   import wesp_pkg::*;

   localparam int CNT_WIDTH = $clog2(DIV_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(DIV_WIDTH - 1);

   logic [DIV_WIDTH-1:0] rem_ff, rem_in;
   logic [DIV_WIDTH-1:0] quo_ff, quo_in;
   logic [DIV_WIDTH-1:0] den_ff, den_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_WIDTH:0]   shifted;
   logic [DIV_WIDTH:0]   diff;
   logic                 take;

   assign shifted = {rem_ff, quo_ff[DIV_WIDTH-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign take    = (shifted >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         rem_in = take ? diff[DIV_WIDTH-1:0] : shifted[DIV_WIDTH-1:0];
         quo_in = {quo_ff[DIV_WIDTH-2:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   `WESP_ASSERT_IMP(a_no_restart, start, !busy_ff)
   `WESP_ASSERT_NEXT(a_start_busy, start, busy_ff && !done_ff)
   `WESP_ASSERT_NEXT(a_last_done, busy_ff && (cnt_ff == CNT_LAST), done_ff && !busy_ff)

endmodule

FILE: rtl/core/wesp_ctrl.sv
// Request sequencer and result valid flag.
`include "wheel_encoder_speed_position_macros.svh"
module wesp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  wesp_pkg::dp_status_type status,
   output wesp_pkg::ctrl_cmd_type  cmd
);
   import wesp_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.div_start = 1'b0;
      cmd.load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               if (status.need_div) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIVIDE;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // hold the result until the output register frees up
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `WESP_ASSERT_NEXT(a_div_entry, cmd.accept && status.need_div, state_ff == ST_DIVIDE)
   `WESP_ASSERT_IMP(a_div_running, state_ff == ST_DIVIDE, status.div_busy || status.div_done)
   `WESP_ASSERT_IMP(a_no_overwrite, cmd.load_rsp, !rsp_valid_ff || rsp_tready)

endmodule

FILE: rtl/core/wesp_dp.sv
// Counters, interval averaging, speed calculation and result register.
module wesp_dp #(
   parameter int TIME_WIDTH = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wesp_pkg::cfg_type                   cfg,
   input  wesp_pkg::ctrl_cmd_type              cmd,
   output wesp_pkg::dp_status_type             status,
   input  logic [wesp_pkg::CMD_WIDTH-1:0]      req_cmd,
   input  logic                                req_b_level,
   output logic [wesp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import wesp_pkg::*;

   localparam int CW = (TIME_WIDTH > STALL_WIDTH) ? TIME_WIDTH : STALL_WIDTH;
   localparam int SW = ((TIME_WIDTH > SUM_WIDTH) ? TIME_WIDTH : SUM_WIDTH) + 1;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

   logic signed [IMP_WIDTH-1:0]   imp_ff,     imp_in;
   logic [REV_WIDTH-1:0]          rev_ff,     rev_in;
   logic signed [DIR_WIDTH-1:0]   dir_ff,     dir_in;
   logic                          moving_ff,  moving_in;
   logic [TIME_WIDTH-1:0]         elapsed_ff, elapsed_in;
   logic                          iv_nz_ff,   iv_nz_in;
   logic [SUM_WIDTH-1:0]          sum_ff,     sum_in;
   logic [AVG_CNT_WIDTH-1:0]      samp_ff,    samp_in;
   logic [DIV_WIDTH-1:0]          avg_ff,     avg_in;
   logic                          ready_ff,   ready_in;
   logic signed [SPEED_WIDTH-1:0] speed_ff,   speed_in;
   logic                          fresh_ff,   fresh_in;
   logic                          div_speed_ff, div_speed_in;
   logic [RSP_DATA_WIDTH-1:0]     rsp_data_ff, rsp_data_in;

   cmd_type                       op;
   logic [TIME_WIDTH-1:0]         elapsed_inc;
   logic                          stall_hit;
   logic signed [IMP_WIDTH:0]     imp_step;
   logic signed [IMP_WIDTH:0]     lim;
   logic                          wrap_up;
   logic                          wrap_dn;
   logic [TIME_WIDTH-1:0]         iv;
   logic [SW-1:0]                 sum_wide;
   logic [SW-1:0]                 iv_wide;
   logic [SUM_WIDTH-1:0]          sum_add;
   logic [SUM_WIDTH-1:0]          iv_sat;
   logic                          group_full;
   logic                          query_ok;
   logic                          div_start;
   logic [DIV_WIDTH-1:0]          div_dividend;
   logic [DIV_WIDTH-1:0]          div_divisor;
   logic                          div_busy;
   logic                          div_done;
   logic [DIV_WIDTH-1:0]          div_quotient;
   logic signed [SPEED_WIDTH-1:0] speed_mag;

   assign op = cmd_type'(req_cmd);

   assign elapsed_inc = (elapsed_ff == TIME_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign stall_hit   = (CW'(elapsed_inc) >= CW'(cfg.stall_limit));

   assign imp_step = req_b_level ? ({imp_ff[IMP_WIDTH-1], imp_ff} - 1'sb1)
                                 : ({imp_ff[IMP_WIDTH-1], imp_ff} + 2'sb01);
   assign lim      = signed'({2'b00, cfg.impulses_per_rev});
   assign wrap_up  = (imp_step >= lim);
   assign wrap_dn  = (imp_step <= -lim);

   assign iv       = moving_ff ? elapsed_ff : '0;
   assign sum_wide = SW'(sum_ff) + SW'(iv);
   assign iv_wide  = SW'(iv);
   // saturate the running sum and a restarted sum at the sum width
   assign sum_add  = (|sum_wide[SW-1:SUM_WIDTH]) ? '1 : sum_wide[SUM_WIDTH-1:0];
   assign iv_sat   = (|iv_wide[SW-1:SUM_WIDTH]) ? '1 : iv_wide[SUM_WIDTH-1:0];

   assign group_full = (samp_ff >= cfg.average_count);
   assign query_ok   = moving_ff && iv_nz_ff && ready_ff;

   always_comb begin
      unique case (op)
         CMD_EDGE:  status.need_div = group_full && (cfg.average_count != '0);
         CMD_QUERY: status.need_div = query_ok && (avg_ff != '0) && (dir_ff != '0);
         default:   status.need_div = 1'b0;
      endcase
   end

   assign div_start    = cmd.div_start;
   assign div_dividend = (op == CMD_EDGE) ? sum_ff : cfg.speed_scale;
   assign div_divisor  = (op == CMD_EDGE) ? DIV_WIDTH'(cfg.average_count) : avg_ff;

   wesp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign status.div_busy = div_busy;
   assign status.div_done = div_done;

   assign speed_mag = signed'({1'b0, div_quotient});

   always_comb begin
      imp_in       = imp_ff;
      rev_in       = rev_ff;
      dir_in       = dir_ff;
      moving_in    = moving_ff;
      elapsed_in   = elapsed_ff;
      iv_nz_in     = iv_nz_ff;
      sum_in       = sum_ff;
      samp_in      = samp_ff;
      avg_in       = avg_ff;
      ready_in     = ready_ff;
      speed_in     = speed_ff;
      fresh_in     = fresh_ff;
      div_speed_in = div_speed_ff;
      if (cmd.accept) begin
         speed_in     = '0;
         fresh_in     = 1'b0;
         div_speed_in = (op == CMD_QUERY);
         unique case (op)
            CMD_TICK: begin
               elapsed_in = elapsed_inc;
               if (stall_hit) begin
                  moving_in = 1'b0;
               end
            end
            CMD_EDGE: begin
               dir_in = req_b_level ? DIR_REV : DIR_FWD;
               priority if (wrap_up) begin
                  imp_in = '0;
                  rev_in = rev_ff + 1'b1;
               end else if (wrap_dn) begin
                  imp_in = '0;
                  rev_in = rev_ff - 1'b1;
               end else begin
                  imp_in = imp_step[IMP_WIDTH-1:0];
               end
               iv_nz_in   = (iv != '0);
               elapsed_in = '0;
               if (!group_full) begin
                  sum_in  = sum_add;
                  samp_in = samp_ff + 1'b1;
               end else begin
                  // publish zero now; the divider overwrites it when it runs
                  avg_in   = '0;
                  ready_in = 1'b1;
                  sum_in   = iv_sat;
                  samp_in  = AVG_CNT_WIDTH'(1);
               end
               moving_in = 1'b1;
            end
            CMD_QUERY: begin
               if (query_ok) begin
                  ready_in = 1'b0;
                  fresh_in = 1'b1;
               end
            end
            CMD_CLEAR: begin
               imp_in = '0;
            end
         endcase
      end else if (div_done) begin
         if (div_speed_ff) begin
            speed_in = dir_ff[DIR_WIDTH-1] ? -speed_mag : speed_mag;
         end else begin
            avg_in = div_quotient;
         end
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.load_rsp) begin
         rsp_data_in = {2'b00, fresh_ff, speed_ff, moving_ff, dir_ff, rev_ff, imp_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         imp_ff       <= '0;
         rev_ff       <= '0;
         dir_ff       <= '0;
         moving_ff    <= 1'b0;
         elapsed_ff   <= '0;
         iv_nz_ff     <= 1'b0;
         sum_ff       <= '0;
         samp_ff      <= '0;
         avg_ff       <= '0;
         ready_ff     <= 1'b0;
         speed_ff     <= '0;
         fresh_ff     <= 1'b0;
         div_speed_ff <= 1'b0;
      end else begin
         imp_ff       <= imp_in;
         rev_ff       <= rev_in;
         dir_ff       <= dir_in;
         moving_ff    <= moving_in;
         elapsed_ff   <= elapsed_in;
         iv_nz_ff     <= iv_nz_in;
         sum_ff       <= sum_in;
         samp_ff      <= samp_in;
         avg_ff       <= avg_in;
         ready_ff     <= ready_in;
         speed_ff     <= speed_in;
         fresh_ff     <= fresh_in;
         div_speed_ff <= div_speed_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

FILE: rtl/core/wheel_encoder_speed_position.sv
// Wheel encoder block: counts impulses and revolutions from channel-A falling edges and
// channel-B level, tracks motion from time-tick requests and answers speed queries in
// signed RPM from averaged edge-to-edge intervals. Each request yields exactly one
// result. An edge that closes an averaging group, and a query that consumes a nonzero
// fresh average, run the divider: both share one serial divider that retires one
// quotient bit per cycle over 24 bits. Ticks, other edges, distance clears and queries
// that find no fresh average go straight to the result. Results sit in an output register,
// so the next request is accepted while the previous result still waits to be taken.
module wheel_encoder_speed_position #(
   parameter int TIME_WIDTH = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // bit 0: b_level, bits 7:1 zero
   input  logic [wesp_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // bits 1:0: cmd
   input  logic [wesp_pkg::CMD_WIDTH-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // 16:0 impulse_count, 48:17 revolution_count, 50:49 direction, 51 moving,
   // 76:52 speed_rpm, 77 speed_fresh, 79:78 zero
   output logic [wesp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wesp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [wesp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [wesp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import wesp_pkg::*;

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   wesp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wesp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wesp_dp #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .req_cmd     (req_tuser),
      .req_b_level (req_tdata[0]),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

FILE: test/tb_wheel_encoder_speed_position.sv
// Self-checking testbench for the wheel encoder speed and position block.
`timescale 1ns / 100ps

module tb_wheel_encoder_speed_position;
   import wesp_pkg::*;

   typedef struct {
      logic signed [IMP_WIDTH-1:0]   impulses;
      logic        [REV_WIDTH-1:0]   revolutions;
      logic signed [DIR_WIDTH-1:0]   dir;
      logic                          moving;
      logic signed [SPEED_WIDTH-1:0] rpm;
      logic                          fresh;
   } reading_type;

   localparam logic [19:0] TICKS_MAX = 20'hFFFFF;
   localparam logic [23:0] SUM_MAX   = 24'hFFFFFF;

   // Wheel state mirror plus the queue of readings still owed by the block.
   class wheel_state_tracker_type;
      bit [IPR_WIDTH-1:0]     ipr;
      bit [STALL_WIDTH-1:0]   stall;
      bit [SCALE_WIDTH-1:0]   scale;
      bit [AVG_CNT_WIDTH-1:0] avg_n;

      int                     impulses;
      bit [REV_WIDTH-1:0]     revs;
      int                     dir;
      bit                     moving;
      bit [19:0]              elapsed;
      bit [19:0]              last_iv;
      bit [SUM_WIDTH-1:0]     iv_sum;
      bit [AVG_CNT_WIDTH-1:0] samples;
      bit [DIV_WIDTH-1:0]     avg_iv;
      bit                     avg_ready;

      reading_type            pending_readings[$];
      int                     mismatches;

      function new();
         ipr   = IPR_RESET;
         stall = STALL_RESET;
         scale = SCALE_RESET;
         avg_n = AVG_CNT_RESET;
      endfunction

      function void write_reg(csr_reg_type r, logic [31:0] v);
         case (r)
            REG_IMPULSES_PER_REV: ipr   = v[IPR_WIDTH-1:0];
            REG_STALL_LIMIT:      stall = v[STALL_WIDTH-1:0];
            REG_SPEED_SCALE:      scale = v[SCALE_WIDTH-1:0];
            REG_AVERAGE_COUNT:    avg_n = v[AVG_CNT_WIDTH-1:0];
         endcase
      endfunction

      function void note_request(cmd_type c, bit b);
         reading_type e;
         bit [19:0] iv;
         int        sum;
         int        speed;
         bit        fresh;
         speed = 0;
         fresh = 0;
         case (c)
            CMD_TICK: begin
               if (elapsed != TICKS_MAX) elapsed++;
               if (elapsed >= stall) moving = 0;
            end
            CMD_EDGE: begin
               if (b) begin
                  dir = -1;
                  impulses--;
               end else begin
                  dir = 1;
                  impulses++;
               end
               if (impulses >= int'(ipr)) begin
                  impulses = 0;
                  revs++;
               end else if (impulses <= -int'(ipr)) begin
                  impulses = 0;
                  revs--;
               end
               iv = moving ? elapsed : 20'd0;
               last_iv = iv;
               elapsed = 0;
               if (samples < avg_n) begin
                  sum = int'(iv_sum) + int'(iv);
                  iv_sum = (sum > int'(SUM_MAX)) ? SUM_MAX : sum[SUM_WIDTH-1:0];
                  samples++;
               end else begin
                  avg_iv = (avg_n != 0) ? iv_sum / avg_n : '0;
                  avg_ready = 1;
                  iv_sum = iv;
                  samples = 1;
               end
               moving = 1;
            end
            CMD_QUERY: begin
               if (moving && last_iv != 0 && avg_ready) begin
                  avg_ready = 0;
                  fresh = 1;
                  if (avg_iv != 0) begin
                     speed = int'(scale / avg_iv);
                     speed = (dir < 0) ? -speed : ((dir > 0) ? speed : 0);
                  end
               end
            end
            CMD_CLEAR: impulses = 0;
         endcase
         e.impulses    = impulses[IMP_WIDTH-1:0];
         e.revolutions = revs;
         e.dir         = dir[DIR_WIDTH-1:0];
         e.moving      = moving;
         e.rpm         = speed[SPEED_WIDTH-1:0];
         e.fresh       = fresh;
         pending_readings.push_back(e);
      endfunction

      function void check_reading(logic [RSP_DATA_WIDTH-1:0] d);
         reading_type e;
         reading_type a;
         a.impulses    = d[16:0];
         a.revolutions = d[48:17];
         a.dir         = d[50:49];
         a.moving      = d[51];
         a.rpm         = d[76:52];
         a.fresh       = d[77];
         if (pending_readings.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: reading with no request outstanding: %h", $realtime, d);
            mismatches++;
            return;
         end
         e = pending_readings.pop_front();
         if (a.impulses !== e.impulses || a.revolutions !== e.revolutions ||
             a.dir !== e.dir || a.moving !== e.moving || a.rpm !== e.rpm ||
             a.fresh !== e.fresh) begin
            if (mismatches < 10) begin
               $write("%0t: imp %0d/%0d rev %0d/%0d dir %0d/%0d ", $realtime,
                      e.impulses, a.impulses, $signed(e.revolutions),
                      $signed(a.revolutions), e.dir, a.dir);
               $display("mov %0d/%0d rpm %0d/%0d fresh %0d/%0d (expected/actual)",
                        e.moving, a.moving, e.rpm, a.rpm, e.fresh, a.fresh);
            end
            mismatches++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;   // bit 0: b_level, bits 7:1 zero
   logic [CMD_WIDTH-1:0]      req_tuser;   // bits 1:0: cmd
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   // 16:0 impulse_count, 48:17 revolution_count, 50:49 direction, 51 moving,
   // 76:52 speed_rpm, 77 speed_fresh, 79:78 zero
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   wheel_state_tracker_type tracker;
   int                      src_idle_pct;
   int                      sink_idle_pct;

   wheel_encoder_speed_position dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Take readings, stalling at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) tracker.check_reading(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   task automatic send(input cmd_type c, input bit b);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {7'b0, b};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_request(c, b);
   endtask

   task automatic ticks(input int n);
      repeat (n) send(CMD_TICK, 1'($urandom_range(1)));
   endtask

   task automatic write_cfg(input csr_reg_type r, input logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.write_reg(r, v);
   endtask

   // Drain outstanding readings, then write all four registers.
   task automatic configure(input logic [31:0] ipr, input logic [31:0] stall,
                            input logic [31:0] scale, input logic [31:0] avg);
      req_tvalid <= 1'b0;
      while (tracker.pending_readings.size() != 0) @(posedge clock);
      write_cfg(REG_IMPULSES_PER_REV, ipr);
      write_cfg(REG_STALL_LIMIT, stall);
      write_cfg(REG_SPEED_SCALE, scale);
      write_cfg(REG_AVERAGE_COUNT, avg);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mostly runs of edges in one direction with short tick gaps, closed by a query.
   task automatic run_phase(input int n_items, input int gap_max, input int stall_gap);
      int sent;
      int r;
      int gap;
      bit b;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(99);
         if (r < 75) begin
            b = 1'($urandom_range(1));
            repeat ($urandom_range(1, 2 * tracker.avg_n + 2)) begin
               gap = $urandom_range(gap_max);
               ticks(gap);
               send(CMD_EDGE, ($urandom_range(15) == 0) ? ~b : b);
               sent += gap + 1;
               if ($urandom_range(3) == 0) begin
                  send(CMD_QUERY, 1'($urandom_range(1)));
                  sent++;
               end
               if (sent >= n_items) break;
            end
            send(CMD_QUERY, 1'($urandom_range(1)));
            sent++;
         end else if (r < 85 && stall_gap > 0) begin
            ticks(stall_gap);
            sent += stall_gap;
         end else begin
            send(cmd_type'($urandom_range(3)), 1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   initial begin
      tracker       = new();
      src_idle_pct  = 13;
      sink_idle_pct = 69;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_TICK;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: small revolution, short stall limit, averages of two intervals.
      configure(3, 5, 12000, 2);
      send(CMD_QUERY, 1'b0);          // not moving yet
      send(CMD_TICK, 1'b1);
      send(CMD_EDGE, 1'b0);           // first edge: interval taken as zero
      send(CMD_QUERY, 1'b0);          // last interval zero
      ticks(2);
      send(CMD_EDGE, 1'b0);
      ticks(3);
      send(CMD_EDGE, 1'b0);           // full revolution forward, average published
      send(CMD_QUERY, 1'b0);          // consumes the fresh average
      send(CMD_QUERY, 1'b0);          // nothing fresh left
      send(CMD_EDGE, 1'b1);
      send(CMD_EDGE, 1'b1);
      send(CMD_QUERY, 1'b1);          // average ready but last interval zero
      ticks(4);
      send(CMD_EDGE, 1'b1);           // full revolution reverse
      send(CMD_QUERY, 1'b0);          // negative speed
      send(CMD_CLEAR, 1'b1);
      ticks(5);                       // reach the stall limit
      send(CMD_QUERY, 1'b0);

      configure(1, 20'hFFFFF, 24'hFFFFFF, 1);
      run_phase(110, 3, 0);

      configure(16'hFFFF, 1, 1, 15);
      run_phase(60, 2, 0);

      src_idle_pct  = 69;
      sink_idle_pct = 13;
      configure(7, 20, 600000, 3);
      run_phase(120, 8, 25);

      src_idle_pct  = 0;
      sink_idle_pct = 0;
      configure($urandom_range(2, 20), $urandom_range(30, 1000), $urandom_range(1, 24'hFFFFFF),
                $urandom_range(1, 15));
      run_phase(110, 12, 0);

      req_tvalid <= 1'b0;
      while (tracker.pending_readings.size() != 0) @(posedge clock);
      // allow for a division still in flight
      repeat (40) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_readings.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/wesp_pkg.sv
rtl/core/wesp_csr.sv
rtl/core/wesp_div.sv
rtl/core/wesp_ctrl.sv
rtl/core/wesp_dp.sv
rtl/core/wheel_encoder_speed_position.sv
test/tb_wheel_encoder_speed_position.sv
